@@ hdl/fbde_pkg.sv @@
// shared types and constants for the two-plane framebuffer draw engine
// no dependencies; every other file of the block refers to it by scoped names
`timescale 1ns / 1ps

package fbde_pkg;

   // default screen size
   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 256;
   localparam int STORE_BYTES_DEF   = ((SCREEN_WIDTH_DEF + 7) / 8) * SCREEN_HEIGHT_DEF;
   localparam int ADDR_W_DEF        = (STORE_BYTES_DEF > 1) ? $clog2(STORE_BYTES_DEF) : 1;

   // memory word: plane one in the upper byte, plane two in the lower byte
   localparam int WORD_W = 16;

   // operation codes
   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_POINT  = 3'd1;
   localparam logic [2:0] OP_HLINE  = 3'd2;
   localparam logic [2:0] OP_VLINE  = 3'd3;
   localparam logic [2:0] OP_HOLLOW = 3'd4;
   localparam logic [2:0] OP_SOLID  = 3'd5;
   localparam logic [2:0] OP_READ   = 3'd6;

   // colour codes
   localparam logic [1:0] COL_WHITE = 2'd0;
   localparam logic [1:0] COL_BLACK = 2'd1;
   localparam logic [1:0] COL_RED   = 2'd2;
   localparam logic [1:0] COL_NONE  = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  start_x;
      logic [7:0]  start_y;
      logic [7:0]  span_width;
      logic [7:0]  span_height;
      logic [1:0]  draw_colour;
      logic [1:0]  interior_colour;
      logic [7:0]  plane_one_even_fill;
      logic [7:0]  plane_one_odd_fill;
      logic [7:0]  plane_two_even_fill;
      logic [7:0]  plane_two_odd_fill;
      logic [11:0] byte_address;
   } req_type;

   typedef struct packed {
      logic [7:0] plane_one_byte;
      logic [7:0] plane_two_byte;
      logic       rejected;
   } rsp_type;

   // one pixel read-modify-write issued by the sequencer
   typedef struct packed {
      logic       valid;
      logic [7:0] mask;
      logic [1:0] colour;
   } pix_type;

   // sequencer's own memory accesses: pixel reads, readback reads and clear writes
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [WORD_W-1:0] wr_data;
   } mem_cmd_type;

   // finished item waiting for the result register
   typedef struct packed {
      logic valid;
      logic rejected;
      logic readback;
   } res_type;

endpackage

@@ hdl/fbde_mem.sv @@
// plane store: one synchronous memory, one write and one read port, registered read data
// depends on fbde_pkg
`timescale 1ns / 1ps

module fbde_mem #(
   parameter int DEPTH  = fbde_pkg::STORE_BYTES_DEF,
   parameter int ADDR_W = fbde_pkg::ADDR_W_DEF
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [fbde_pkg::WORD_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [fbde_pkg::WORD_W-1:0] wr_data
);

   logic [fbde_pkg::WORD_W-1:0] plane_ff [DEPTH];
   logic [fbde_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         plane_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= plane_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/fbde_rmw.sv @@
// pixel read-modify-write stage with one-deep write forwarding
// depends on fbde_pkg
`timescale 1ns / 1ps

module fbde_rmw #(
   parameter int ADDR_W = fbde_pkg::ADDR_W_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fbde_pkg::pix_type           pix,
   input  logic [ADDR_W-1:0]           pix_addr,
   input  logic [fbde_pkg::WORD_W-1:0] rd_data,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [fbde_pkg::WORD_W-1:0] wr_data
);

   logic                        b_valid_ff;
   logic [ADDR_W-1:0]           b_addr_ff;
   logic [7:0]                  b_mask_ff;
   logic [1:0]                  b_colour_ff;
   logic                        hit_ff;
   logic                        hit_in;
   logic [fbde_pkg::WORD_W-1:0] fwd_ff;
   logic [fbde_pkg::WORD_W-1:0] base_word;
   logic [fbde_pkg::WORD_W-1:0] new_word;

   // a read issued while the same byte is written returns stale data
   assign hit_in = pix.valid && b_valid_ff && (pix_addr == b_addr_ff);

   always_comb begin
      base_word = hit_ff ? fwd_ff : rd_data;
      new_word  = base_word;
      case (b_colour_ff)
         fbde_pkg::COL_WHITE: begin
            new_word = base_word & ~{b_mask_ff, b_mask_ff};
         end
         fbde_pkg::COL_BLACK: begin
            new_word = {base_word[15:8] | b_mask_ff, base_word[7:0] & ~b_mask_ff};
         end
         fbde_pkg::COL_RED: begin
            new_word = {base_word[15:8] & ~b_mask_ff, base_word[7:0] | b_mask_ff};
         end
         default: begin
            new_word = base_word;
         end
      endcase
   end

   assign wr_en   = b_valid_ff;
   assign wr_addr = b_addr_ff;
   assign wr_data = new_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         b_valid_ff <= pix.valid;
         hit_ff     <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      b_addr_ff   <= pix_addr;
      b_mask_ff   <= pix.mask;
      b_colour_ff <= pix.colour;
      fwd_ff      <= new_word;
   end

endmodule

@@ hdl/fbde_seq.sv @@
// operation sequencer: bounds check, pixel scan, clear sweep and readback
// depends on fbde_pkg
`timescale 1ns / 1ps

module fbde_seq #(
   parameter  int SCREEN_WIDTH  = fbde_pkg::SCREEN_WIDTH_DEF,
   parameter  int SCREEN_HEIGHT = fbde_pkg::SCREEN_HEIGHT_DEF,
   localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8,
   localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT,
   localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fbde_pkg::req_type     req_data,
   output logic [ADDR_W-1:0]     mem_addr,
   output fbde_pkg::mem_cmd_type mem_cmd,
   output fbde_pkg::pix_type     pix,
   output fbde_pkg::res_type     res,
   input  logic                  res_taken
);

   localparam int         RB_W        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam logic [8:0] X_LAST      = 9'(SCREEN_WIDTH - 1);
   localparam logic [8:0] Y_LAST      = 9'(SCREEN_HEIGHT - 1);
   localparam logic [13:0] STORE_LIMIT = 14'(STORE_BYTES);

   typedef enum logic [5:0] {
      ST_WIPE  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SETUP = 6'b000100,
      ST_FILL  = 6'b001000,
      ST_DRAW  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   fbde_pkg::req_type req_ff, req_in;
   logic              rej_ff, rej_in;
   logic [7:0]        col_ff, col_in;
   logic [7:0]        col_last_ff, col_last_in;
   logic [7:0]        row_ff, row_in;
   logic [7:0]        row_last_ff, row_last_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] fill_addr_ff, fill_addr_in;
   logic [RB_W-1:0]   fill_col_ff, fill_col_in;
   logic              fill_odd_ff, fill_odd_in;

   logic [7:0]        span_x;
   logic [7:0]        span_y;
   logic [8:0]        x_end;
   logic [8:0]        y_end;
   logic              start_ok;
   logic              rej_draw;
   logic              rej_read;
   logic              is_draw_op;
   logic              solid;
   logic              last_col;
   logic              last_row;
   logic              edge_row;
   logic              border;
   logic              fill_last;
   logic [15:0]       fill_word;
   logic [ADDR_W-1:0] pix_addr;

   // lines and points as degenerate rectangles
   always_comb begin
      span_x = req_ff.span_width;
      span_y = req_ff.span_height;
      case (req_ff.operation)
         fbde_pkg::OP_POINT: begin
            span_x = 8'd1;
            span_y = 8'd1;
         end
         fbde_pkg::OP_HLINE: begin
            span_y = 8'd1;
         end
         fbde_pkg::OP_VLINE: begin
            span_x = 8'd1;
            span_y = req_ff.span_width;
         end
         default: begin
            span_y = req_ff.span_height;
         end
      endcase
   end

   assign x_end    = {1'b0, req_ff.start_x} + {1'b0, span_x} - 9'd1;
   assign y_end    = {1'b0, req_ff.start_y} + {1'b0, span_y} - 9'd1;
   assign start_ok = ({1'b0, req_ff.start_x} <= X_LAST) && ({1'b0, req_ff.start_y} <= Y_LAST);
   assign rej_draw = !start_ok || ((span_x != 8'd0) && (x_end > X_LAST)) ||
                     ((span_y != 8'd0) && (y_end > Y_LAST));
   assign rej_read = {2'b00, req_ff.byte_address} >= STORE_LIMIT;
   assign is_draw_op = (req_ff.operation == fbde_pkg::OP_POINT) ||
                       (req_ff.operation == fbde_pkg::OP_HLINE) ||
                       (req_ff.operation == fbde_pkg::OP_VLINE) ||
                       (req_ff.operation == fbde_pkg::OP_HOLLOW) ||
                       (req_ff.operation == fbde_pkg::OP_SOLID);
   assign solid    = req_ff.operation == fbde_pkg::OP_SOLID;

   // pixel scan position
   assign last_col = col_ff == col_last_ff;
   assign last_row = row_ff == row_last_ff;
   assign edge_row = (row_ff == 8'd0) || last_row;
   assign border   = edge_row || (col_ff == req_ff.start_x) || last_col;
   assign pix_addr = base_ff + ADDR_W'(col_ff[7:3]);

   // clear sweep
   assign fill_last = fill_addr_ff == ADDR_W'(STORE_BYTES - 1);
   always_comb begin
      if (state_ff == ST_WIPE) begin
         fill_word = 16'h0000;
      end else if (fill_odd_ff) begin
         fill_word = {req_ff.plane_one_odd_fill, req_ff.plane_two_odd_fill};
      end else begin
         fill_word = {req_ff.plane_one_even_fill, req_ff.plane_two_even_fill};
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rej_in       = rej_ff;
      col_in       = col_ff;
      col_last_in  = col_last_ff;
      row_in       = row_ff;
      row_last_in  = row_last_ff;
      base_in      = base_ff;
      fill_addr_in = fill_addr_ff;
      fill_col_in  = fill_col_ff;
      fill_odd_in  = fill_odd_ff;

      req_stall       = state_ff != ST_IDLE;
      mem_addr        = fill_addr_ff;
      mem_cmd.rd_en   = 1'b0;
      mem_cmd.wr_en   = 1'b0;
      mem_cmd.wr_data = fill_word;
      pix.valid       = 1'b0;
      pix.mask        = 8'h80 >> col_ff[2:0];
      pix.colour      = border ? req_ff.draw_colour :
                        (solid ? req_ff.interior_colour : fbde_pkg::COL_NONE);
      res.valid       = state_ff == ST_DONE;
      res.rejected    = rej_ff;
      res.readback    = (req_ff.operation == fbde_pkg::OP_READ) && !rej_ff;

      case (state_ff)
         ST_WIPE, ST_FILL: begin
            mem_cmd.wr_en = 1'b1;
            fill_addr_in  = fill_addr_ff + ADDR_W'(1);
            if (fill_col_ff == RB_W'(ROW_BYTES - 1)) begin
               fill_col_in = '0;
               fill_odd_in = !fill_odd_ff;
            end else begin
               fill_col_in = fill_col_ff + RB_W'(1);
            end
            if (fill_last) begin
               state_in = (state_ff == ST_WIPE) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            col_in       = req_ff.start_x;
            col_last_in  = x_end[7:0];
            row_in       = 8'd0;
            row_last_in  = span_y - 8'd1;
            base_in      = ADDR_W'(32'(req_ff.start_y) * ROW_BYTES);
            fill_addr_in = '0;
            fill_col_in  = '0;
            fill_odd_in  = 1'b0;
            mem_addr     = ADDR_W'(req_ff.byte_address);
            if (is_draw_op) begin
               rej_in = rej_draw;
            end else if (req_ff.operation == fbde_pkg::OP_READ) begin
               rej_in = rej_read;
            end else begin
               rej_in = 1'b0;
            end
            if (req_ff.operation == fbde_pkg::OP_CLEAR) begin
               state_in = ST_FILL;
            end else if (is_draw_op && !rej_draw && (span_x != 8'd0) && (span_y != 8'd0)) begin
               state_in = ST_DRAW;
            end else begin
               // readback data lands while in done and holds there
               mem_cmd.rd_en = (req_ff.operation == fbde_pkg::OP_READ) && !rej_read;
               state_in      = ST_DONE;
            end
         end
         ST_DRAW: begin
            mem_addr      = pix_addr;
            mem_cmd.rd_en = 1'b1;
            pix.valid     = 1'b1;
            if (last_col) begin
               if (last_row) begin
                  state_in = ST_DONE;
               end else begin
                  row_in  = row_ff + 8'd1;
                  base_in = base_ff + ADDR_W'(ROW_BYTES);
                  col_in  = req_ff.start_x;
               end
            end else if (!edge_row && !solid && (col_ff == req_ff.start_x)) begin
               // hollow interior row: jump to the right edge
               col_in = col_last_ff;
            end else begin
               col_in = col_ff + 8'd1;
            end
         end
         ST_DONE: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         fill_addr_ff <= '0;
         fill_col_ff  <= '0;
         fill_odd_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_addr_ff <= fill_addr_in;
         fill_col_ff  <= fill_col_in;
         fill_odd_ff  <= fill_odd_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rej_ff      <= rej_in;
      col_ff      <= col_in;
      col_last_ff <= col_last_in;
      row_ff      <= row_in;
      row_last_ff <= row_last_in;
      base_ff     <= base_in;
   end

endmodule

@@ hdl/two_plane_framebuffer_draw_engine_core.sv @@
// top level of the two-plane framebuffer draw engine
// depends on fbde_pkg, fbde_mem, fbde_rmw and fbde_seq
`timescale 1ns / 1ps

// Two-plane framebuffer draw engine. Both planes share one memory of
// ceil(SCREEN_WIDTH/8) * SCREEN_HEIGHT 16-bit words (plane one in the upper
// byte), so one memory port pair sets the pace: the engine starts one pixel
// read-modify-write per cycle and works on one operation at a time. An
// operation draws its pixels (1 for a point, the length for a line,
// width * height for a solid rectangle, the border pixels once each for a
// hollow one, which is 2 * width + 2 * (height - 2) when both are at least
// 2), a clear writes every word of the memory, and a readback or a rejected
// or empty operation draws nothing. After reset the engine sweeps zeros
// through the whole memory, one word per cycle, and holds req_stall high
// meanwhile. A finished result waits in an output register, so the next
// request can be taken while the previous result is still stalled.

module two_plane_framebuffer_draw_engine_core #(
   parameter int SCREEN_WIDTH  = fbde_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = fbde_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fbde_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fbde_pkg::rsp_type rsp_data
);

   localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   // sequencer side
   logic [ADDR_W-1:0]           seq_addr;
   fbde_pkg::mem_cmd_type       seq_cmd;
   fbde_pkg::pix_type           pix;
   fbde_pkg::res_type           res;
   logic                        res_taken;

   // read-modify-write side
   logic                        rmw_wr_en;
   logic [ADDR_W-1:0]           rmw_wr_addr;
   logic [fbde_pkg::WORD_W-1:0] rmw_wr_data;

   // memory ports
   logic                        mem_wr_en;
   logic [ADDR_W-1:0]           mem_wr_addr;
   logic [fbde_pkg::WORD_W-1:0] mem_wr_data;
   logic [fbde_pkg::WORD_W-1:0] mem_rd_data;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   fbde_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   fbde_seq #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .mem_addr  (seq_addr),
      .mem_cmd   (seq_cmd),
      .pix       (pix),
      .res       (res),
      .res_taken (res_taken)
   );

   fbde_rmw #(
      .ADDR_W (ADDR_W)
   ) u_rmw (
      .clock    (clock),
      .reset    (reset),
      .pix      (pix),
      .pix_addr (seq_addr),
      .rd_data  (mem_rd_data),
      .wr_en    (rmw_wr_en),
      .wr_addr  (rmw_wr_addr),
      .wr_data  (rmw_wr_data)
   );

   // clear sweeps and pixel write-backs never overlap in time
   assign mem_wr_en   = seq_cmd.wr_en || rmw_wr_en;
   assign mem_wr_addr = seq_cmd.wr_en ? seq_addr : rmw_wr_addr;
   assign mem_wr_data = seq_cmd.wr_en ? seq_cmd.wr_data : rmw_wr_data;

   fbde_mem #(
      .DEPTH  (STORE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (seq_cmd.rd_en),
      .rd_addr (seq_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // result register loads when empty or when its current transfer completes
   assign res_taken    = res.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_taken || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (res_taken) begin
         rsp_data_in.rejected = res.rejected;
         if (res.readback) begin
            rsp_data_in.plane_one_byte = mem_rd_data[15:8];
            rsp_data_in.plane_two_byte = mem_rd_data[7:0];
         end else begin
            // only a readback returns plane bytes
            rsp_data_in.plane_one_byte = 8'h00;
            rsp_data_in.plane_two_byte = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/fbde_chk.sv @@
// port-level checks for the two-plane framebuffer draw engine, bound to the top level
// depends on fbde_pkg and two_plane_framebuffer_draw_engine_core
`timescale 1ns / 1ps

module fbde_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fbde_pkg::rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no result straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one operation at a time: a request transfer is never followed by another at once
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("back-to-back request transfers");

   // the reset wipe keeps requests out
   a_wipe_stall: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request taken during reset wipe");

   // plane bytes come only from an accepted readback
   a_bytes_only_readback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.plane_one_byte != 8'h00) || (rsp_data.plane_two_byte != 8'h00))
      |-> !rsp_data.rejected)
      else $error("rejected result carries plane bytes");

endmodule

bind two_plane_framebuffer_draw_engine_core fbde_chk u_fbde_chk (.*);
